>>> rtl/core/sgvs_pkg.sv
// Shared types and constants of the skewed grid velocity sampler.
package sgvs_pkg;

  // Address width that covers the largest grid the block can be built for.
  localparam int ADDR_W = 20;

  // Fixed field widths.
  localparam int VW = 16;

  // Request kinds carried in the op field.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_COLS  = 3'd0;
  localparam logic [2:0] REG_ROWS  = 3'd1;
  localparam logic [2:0] REG_SHEAR = 3'd2;
  localparam logic [2:0] REG_SXI   = 3'd3;
  localparam logic [2:0] REG_SETA  = 3'd4;
  localparam logic [2:0] REG_TOPV  = 3'd5;

  typedef struct packed {
    logic        [7:0]    cols;
    logic        [7:0]    rows;
    logic signed [23:0]   shear;
    logic        [31:0]   sxi;
    logic        [31:0]   seta;
    logic signed [VW-1:0] topv;
  } cfg_t;

  // One classified request on its way from the front part to the back part.
  typedef struct packed {
    logic                         wr;
    logic                         wr_ok;
    logic [3:0][ADDR_W-1:0]       addr;
    logic [31:0]                  wdata;
    logic [15:0]                  fx;
    logic [15:0]                  fy;
    logic                         outside;
    logic signed [VW-1:0]         velx;
  } job_t;

endpackage

>>> rtl/core/sgvs_front.sv
// Front part: maps query points to grid cells and classifies each request.
module sgvs_front #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  sgvs_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [13:0]       in_index,
  input  logic [15:0]       in_vx,
  input  logic [15:0]       in_vy,
  input  logic signed [23:0] in_px,
  input  logic signed [23:0] in_py,
  output logic              job_valid,
  output sgvs_pkg::job_t    job,
  input  logic              q_full
);

  localparam int   DEPTH    = MAX_COLS * MAX_ROWS;
  localparam logic signed [23:0] G_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] G_MIN = -24'sh800000;
  localparam logic [10:0] MAXC = 11'(MAX_COLS);
  localparam logic [10:0] MAXR = 11'(MAX_ROWS);

  logic fen;
  assign fen      = !(job_valid && q_full);
  assign in_ready = fen;

  // Stage 1: shear product.
  logic                v1, wr1;
  logic [13:0]         idx1;
  logic [31:0]         wd1;
  logic signed [23:0]  px1, py1;
  logic signed [47:0]  psh1;

  // Stage 2: magnitudes of the skewed offsets.
  logic                v2, wr2, nx2, ny2;
  logic [13:0]         idx2;
  logic [31:0]         wd2;
  logic [47:0]         mx2, my2;

  // Stage 3: scale products.
  logic                v3, wr3, nx3, ny3;
  logic [13:0]         idx3;
  logic [31:0]         wd3;
  logic [55:0]         phx3, plx3, phy3, ply3;

  // Stage 4: grid coordinates.
  logic                v4, wr4;
  logic [13:0]         idx4;
  logic [31:0]         wd4;
  logic signed [23:0]  gx4, gy4;

  logic signed [48:0]  dx;
  logic signed [39:0]  dy;

  assign dx = 49'(signed'({px1, 16'h0000})) - 49'(psh1);
  assign dy = {py1, 16'h0000};

  function automatic logic signed [23:0] finish(input logic neg, input logic [55:0] ph,
                                               input logic [55:0] pl);
    logic [56:0] p;
    logic [28:0] q;
    logic [56:0] pr;
    p  = 57'({ph[26:0], 24'h000000}) + 57'(pl);
    pr = p + 57'(28'hFFFFFFF);
    if (ph[55:27] != '0) begin
      finish = neg ? G_MIN : G_MAX;
    end else if (!neg) begin
      q = p[56:28];
      finish = (q > 29'(G_MAX)) ? G_MAX : 24'(q);
    end else begin
      q = pr[56:28];
      finish = (q > 29'd8388608) ? G_MIN : 24'(-q);
    end
  endfunction

  // Stage 5 classification, combinational from stage 4.
  logic signed [7:0]   ci, cj;
  logic signed [11:0]  ie, je, nxm1, nym1;
  logic [10:0]         nx, ny;
  logic                top, outc;
  logic [20:0]         base;

  always_comb begin
    ci   = gx4[23:16];
    cj   = gy4[23:16];
    nx   = (11'(cfg.cols) > MAXC) ? MAXC : 11'(cfg.cols);
    ny   = (11'(cfg.rows) > MAXR) ? MAXR : 11'(cfg.rows);
    ie   = 12'(ci);
    je   = 12'(cj);
    nxm1 = signed'({1'b0, nx}) - 12'sd1;
    nym1 = signed'({1'b0, ny}) - 12'sd1;
    top  = je >= nym1;
    outc = ci[7] || (ie >= nxm1) || cj[7] || top;
    base = 21'(cj[6:0] * nx) + 21'(ci[6:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      job_valid <= 1'b0;
    end else if (fen) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      job_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      wr1  <= (in_op == sgvs_pkg::OP_WRITE);
      idx1 <= in_index;
      wd1  <= {in_vy, in_vx};
      px1  <= in_px;
      py1  <= in_py;
      psh1 <= in_py * cfg.shear;

      wr2  <= wr1;
      idx2 <= idx1;
      wd2  <= wd1;
      nx2  <= dx[48];
      mx2  <= dx[48] ? 48'(-dx) : 48'(dx);
      ny2  <= dy[39];
      my2  <= dy[39] ? 48'(-dy) : 48'(dy);

      wr3  <= wr2;
      idx3 <= idx2;
      wd3  <= wd2;
      nx3  <= nx2;
      ny3  <= ny2;
      phx3 <= mx2[47:24] * cfg.sxi;
      plx3 <= mx2[23:0]  * cfg.sxi;
      phy3 <= my2[47:24] * cfg.seta;
      ply3 <= my2[23:0]  * cfg.seta;

      wr4  <= wr3;
      idx4 <= idx3;
      wd4  <= wd3;
      gx4  <= finish(nx3, phx3, plx3);
      gy4  <= finish(ny3, phy3, ply3);

      job.wr      <= wr4;
      job.wr_ok   <= 21'(idx4) < 21'(DEPTH);
      job.wdata   <= wd4;
      job.fx      <= gx4[15:0];
      job.fy      <= gy4[15:0];
      job.outside <= outc;
      job.velx    <= top ? cfg.topv : '0;
      if (wr4) begin
        job.addr[0] <= sgvs_pkg::ADDR_W'(idx4);
        job.addr[1] <= sgvs_pkg::ADDR_W'(idx4);
        job.addr[2] <= sgvs_pkg::ADDR_W'(idx4);
        job.addr[3] <= sgvs_pkg::ADDR_W'(idx4);
      end else begin
        job.addr[0] <= sgvs_pkg::ADDR_W'(base);
        job.addr[1] <= sgvs_pkg::ADDR_W'(base + 21'd1);
        job.addr[2] <= sgvs_pkg::ADDR_W'(base + 21'(nx));
        job.addr[3] <= sgvs_pkg::ADDR_W'(base + 21'(nx) + 21'd1);
      end
    end
  end

endmodule

>>> rtl/core/sgvs_queue.sv
// Short request queue between the front and back parts.
module sgvs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sgvs_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sgvs_pkg::job_t head
);

  localparam int QD = 4;
  localparam int QW = $clog2(QD);

  sgvs_pkg::job_t slot [QD];
  logic [QW-1:0]  wp, rp;
  logic [QW:0]    count;

  assign full       = count == (QW+1)'(QD);
  assign head_valid = count != '0;
  assign head       = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      count <= count + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wp] <= push_job;
  end

endmodule

>>> rtl/core/sgvs_back.sv
// Back part: grid store in four replicated banks and the bilinear blend pipeline.
module sgvs_back #(
  parameter int MAX_COLS  = 128,
  parameter int MAX_ROWS  = 128,
  parameter int VEL_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  sgvs_pkg::job_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    out_vx,
  output logic [15:0]    out_vy,
  output logic           out_outside
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [33:0] VMAX = 34'((64'sd1 <<< (VEL_WIDTH - 1)) - 64'sd1);
  localparam logic signed [33:0] VMIN = -VMAX - 34'sd1;

  logic badv;
  assign badv = !out_valid || out_ready;
  assign pop  = badv && head_valid;

  // Each bank holds a full copy so the four corners read together.
  logic [31:0] rd [4];

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [31:0] mem [DEPTH];
    always_ff @(posedge clk) begin
      if (pop && head.wr && head.wr_ok) mem[AW'(head.addr[k])] <= head.wdata;
      if (badv) rd[k] <= mem[AW'(head.addr[k])];
    end
  end

  logic        v1, v2, v3, v4;
  logic        o1, o2, o3, o4;
  logic [15:0] fx1, fy1, fy2, fy3;
  logic signed [15:0] vx1, vx2, vx3, vx4;
  logic signed [15:0] v00 [2], v01 [2];
  logic signed [33:0] pa [2], pb [2];
  logic signed [33:0] a3 [2], a4 [2];
  logic signed [34:0] d3 [2];
  logic signed [51:0] p4 [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (badv) begin
      v1 <= pop && !head.wr;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  logic signed [53:0] r [2];
  logic signed [33:0] q [2];
  logic [15:0]        res [2];

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      r[c] = (54'(a4[c]) <<< 16) + 54'(p4[c]) + 54'sd2147483648;
      q[c] = 34'(signed'(r[c][53:32]));
      if (q[c] > VMAX)      res[c] = VMAX[15:0];
      else if (q[c] < VMIN) res[c] = VMIN[15:0];
      else                  res[c] = q[c][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (badv) begin
      fx1 <= head.fx;
      fy1 <= head.fy;
      o1  <= head.outside;
      vx1 <= head.velx;

      fy2 <= fy1;
      o2  <= o1;
      vx2 <= vx1;
      for (int c = 0; c < 2; c++) begin
        v00[c] <= signed'(rd[0][16*c +: 16]);
        v01[c] <= signed'(rd[2][16*c +: 16]);
        pa[c]  <= (17'(signed'(rd[1][16*c +: 16])) - 17'(signed'(rd[0][16*c +: 16])))
                  * signed'({1'b0, fx1});
        pb[c]  <= (17'(signed'(rd[3][16*c +: 16])) - 17'(signed'(rd[2][16*c +: 16])))
                  * signed'({1'b0, fx1});
      end

      fy3 <= fy2;
      o3  <= o2;
      vx3 <= vx2;
      for (int c = 0; c < 2; c++) begin
        a3[c] <= (34'(v00[c]) <<< 16) + pa[c];
        d3[c] <= 35'((34'(v01[c]) <<< 16) + pb[c]) - 35'((34'(v00[c]) <<< 16) + pa[c]);
      end

      o4  <= o3;
      vx4 <= vx3;
      for (int c = 0; c < 2; c++) begin
        a4[c] <= a3[c];
        p4[c] <= 52'(d3[c] * signed'({1'b0, fy3}));
      end

      out_outside <= o4;
      out_vx      <= o4 ? vx4 : res[0];
      out_vy      <= o4 ? 16'h0000 : res[1];
    end
  end

endmodule

>>> rtl/core/skewed_grid_velocity_sampler_unit.sv
// Top level of the skewed grid velocity sampler: ports, registers, front, queue, back.
//
//  channel   direction  handshake                     content
//  s_axis    in         s_axis_tvalid/s_axis_tready   grid write or point query
//  m_axis    out        m_axis_tvalid/m_axis_tready   sampled velocity, one per query
//  cfg       in         cfg_we                        register write, no read-back
//
// One request is taken every cycle while s_axis_tready is high; the rate is set by the
// four replicated grid banks, which give all four cell corners in a single read. A
// query's result passes five front stages (the first loads at the edge that accepts it),
// the queue, then the read and four blend stages. Reset clears only control state; the
// grid is undefined until written. A stalled output holds the back part, the queue
// absorbs the front part, and s_axis_tready drops only while the queue is full and the
// front's last stage holds a request.
module skewed_grid_velocity_sampler_unit #(
  parameter int MAX_COLS  = 128,
  parameter int MAX_ROWS  = 128,
  parameter int VEL_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index[13:0], entry_vx[29:14], entry_vy[45:30], point_x[69:46],
  // point_y[93:70], zero fill above
  input  logic [95:0] s_axis_tdata,
  // op
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // vel_x[15:0], vel_y[31:16]
  output logic [31:0] m_axis_tdata,
  // outside
  output logic        m_axis_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  sgvs_pkg::cfg_t cfg;

  // Writes to indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cols  <= 8'd128;
      cfg.rows  <= 8'd128;
      cfg.shear <= '0;
      cfg.sxi   <= 32'd65536;
      cfg.seta  <= 32'd65536;
      cfg.topv  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sgvs_pkg::REG_COLS:  cfg.cols  <= cfg_wdata[7:0];
        sgvs_pkg::REG_ROWS:  cfg.rows  <= cfg_wdata[7:0];
        sgvs_pkg::REG_SHEAR: cfg.shear <= cfg_wdata[23:0];
        sgvs_pkg::REG_SXI:   cfg.sxi   <= cfg_wdata;
        sgvs_pkg::REG_SETA:  cfg.seta  <= cfg_wdata;
        sgvs_pkg::REG_TOPV:  cfg.topv  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic           f_valid, q_full, q_pop, q_head_valid;
  sgvs_pkg::job_t f_job, q_head;

  sgvs_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_index  (s_axis_tdata[13:0]),
    .in_vx     (s_axis_tdata[29:14]),
    .in_vy     (s_axis_tdata[45:30]),
    .in_px     (s_axis_tdata[69:46]),
    .in_py     (s_axis_tdata[93:70]),
    .job_valid (f_valid),
    .job       (f_job),
    .q_full    (q_full)
  );

  // The front's last stage pushes whenever it holds a request and there is room.
  sgvs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid && !q_full),
    .push_job   (f_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  sgvs_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .VEL_WIDTH (VEL_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_vx      (m_axis_tdata[15:0]),
    .out_vy      (m_axis_tdata[31:16]),
    .out_outside (m_axis_tuser)
  );

endmodule
